### design/gbba_pkg.sv
package gbba_pkg;

  localparam int MAX_GROUPS       = 8;
  localparam int GROUP_BLOCKS     = 1024;
  localparam int WORD_BITS        = 32;
  localparam int WORDS_PER_GROUP  = GROUP_BLOCKS / WORD_BITS;
  localparam int BITMAP_WORDS     = MAX_GROUPS * WORDS_PER_GROUP;

  localparam int GRP_W  = 3;
  localparam int NGRP_W = 4;
  localparam int WIG_W  = 5;
  localparam int BIT_W  = 5;
  localparam int ADDR_W = GRP_W + WIG_W;
  localparam int BIG_W  = WIG_W + BIT_W;
  localparam int CNT_W  = 11;
  localparam int BLK_W  = 14;
  localparam int ST_W   = 3;
  localparam int CIDX_W = 1;
  localparam int CDAT_W = 4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [ST_W-1:0] ST_REFUSED = 3'd3;
  localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_GROUPS = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_FDB    = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_GSTART, S_SCAN, S_MRD, S_MWR, S_FRD, S_FWR, S_FIN
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] hit_pos;
    logic [CNT_W-1:0] cand_len;
    logic [BIT_W-1:0] cand_pos;
    logic             cand_prev;
    logic [CNT_W-1:0] run_out;
  } scan_t;

endpackage

### design/gbba_bitmap_ram.sv
module gbba_bitmap_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbba_pkg::ADDR_W-1:0]   rd_addr,
  input  logic                          wr_en,
  input  logic [gbba_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [gbba_pkg::WORD_BITS-1:0] wr_data,
  output logic [gbba_pkg::WORD_BITS-1:0] rd_data
);
  import gbba_pkg::*;

  logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // a word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rvld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

### design/gbba_run_scan.sv
module gbba_run_scan (
  input  logic [gbba_pkg::WORD_BITS-1:0] word,
  input  logic [gbba_pkg::CNT_W-1:0]     run_in,
  input  logic [gbba_pkg::CNT_W-1:0]     want,
  input  logic                           is_last,
  output gbba_pkg::scan_t                res
);
  import gbba_pkg::*;

  logic [CNT_W-1:0] run_at [WORD_BITS];
  logic [WORD_BITS-1:0] ends;
  logic [CNT_W-1:0] tl [6][WORD_BITS];
  logic [BIT_W-1:0] tp [6][WORD_BITS];

  // run length ending at each bit, from the nearest used bit below it, else extended from run_in
  always_comb begin
    logic [WORD_BITS-1:0] below;
    logic found;
    int m;
    for (int p = 0; p < WORD_BITS; p++) begin
      below = word & ~({WORD_BITS{1'b1}} << p);
      found = 1'b0;
      m = 0;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (below[k]) begin
          found = 1'b1;
          m = k;
        end
      end
      if (word[p]) begin
        run_at[p] = '0;
      end else if (found) begin
        run_at[p] = CNT_W'(p - m);
      end else begin
        run_at[p] = CNT_W'(p + 1) + run_in;
      end
    end
  end

  always_comb begin
    res.hit = 1'b0;
    res.hit_pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (run_at[p] >= want) begin
        res.hit = 1'b1;
        res.hit_pos = BIT_W'(p);
      end
    end
  end

  // runs that close in this word; the top bit closes only at group end
  always_comb begin
    for (int p = 0; p < WORD_BITS - 1; p++) begin
      ends[p] = !word[p] && word[p+1];
    end
    ends[WORD_BITS-1] = !word[WORD_BITS-1] && is_last;
  end

  // longest closed run, lower position wins ties
  always_comb begin
    for (int l = 0; l < 6; l++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        tl[l][j] = '0;
        tp[l][j] = '0;
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      tl[0][j] = ends[j] ? run_at[j] : '0;
      tp[0][j] = BIT_W'(j);
    end
    for (int l = 1; l < 6; l++) begin
      for (int j = 0; j < (WORD_BITS >> l); j++) begin
        if (tl[l-1][2*j+1] > tl[l-1][2*j]) begin
          tl[l][j] = tl[l-1][2*j+1];
          tp[l][j] = tp[l-1][2*j+1];
        end else begin
          tl[l][j] = tl[l-1][2*j];
          tp[l][j] = tp[l-1][2*j];
        end
      end
    end
    // a run carried in from the previous word closes at bit 0 here and comes first
    if (word[0] && (run_in != '0) && (run_in >= tl[5][0])) begin
      res.cand_len  = run_in;
      res.cand_pos  = '0;
      res.cand_prev = 1'b1;
    end else begin
      res.cand_len  = tl[5][0];
      res.cand_pos  = tp[5][0];
      res.cand_prev = 1'b0;
    end
    res.run_out  = run_at[WORD_BITS-1];
  end

endmodule

### design/grouped_bitmap_block_allocator.sv
// Channel  | Ports                                        | Handshake
// input    | in_req_type in_start_grp in_requested_count  | start & !busy
//          | in_block_number                              |
// result   | out_status out_first_block                   | out_valid, one cycle
//          | out_grant_count out_total_free               |
// config   | cfg_index cfg_data                           | cfg_valid & cfg_ready
//
// A free goes from S_CHECK through S_FRD and S_FWR to S_FIN, which sets out_valid.
// An allocate scans one bitmap word per cycle through the single read port:
// S_GSTART visits the groups in turn, S_SCAN reads each group's words, and
// S_MRD and S_MWR mark each word of the chosen run before S_FIN.
// Reset is synchronous; the bitmap resets to all free through per-word valid bits.
// The result cannot be stalled; busy stays high until the strobe cycle.
module grouped_bitmap_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [2:0]                     in_start_grp,
  input  logic [10:0]                    in_requested_count,
  input  logic [13:0]                    in_block_number,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [13:0]                    out_first_block,
  output logic [10:0]                    out_grant_count,
  output logic [13:0]                    out_total_free,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbba_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [gbba_pkg::CDAT_W-1:0]    cfg_data
);
  import gbba_pkg::*;

  state_t state_r, state_nxt;

  logic [NGRP_W-1:0] groups_r;
  logic fdb_r;
  logic [CNT_W-1:0] free_cnt_r [MAX_GROUPS];

  logic req_r;
  logic [GRP_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] want_r, want_nxt;
  logic [BLK_W-1:0] blk_r;
  logic [ST_W-1:0] status_r, status_nxt;
  logic [NGRP_W-1:0] i_r, i_nxt;
  logic [GRP_W-1:0] g_r, g_nxt;
  logic [WIG_W-1:0] w_r, w_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] best_len_r, best_len_nxt;
  logic [GRP_W-1:0] best_g_r, best_g_nxt;
  logic [BIG_W-1:0] best_s_r, best_s_nxt;
  logic [BLK_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] granted_r, granted_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [ST_W-1:0] out_status_r;
  logic [BLK_W-1:0] out_first_r;
  logic [CNT_W-1:0] out_count_r;
  logic [BLK_W-1:0] out_total_r;

  logic [NGRP_W-1:0] ngroups;
  logic [BLK_W-1:0] sum_free;
  logic [BLK_W-1:0] real_blk;
  logic [GRP_W-1:0] free_g;
  logic [NGRP_W:0] g_raw;
  logic [GRP_W-1:0] g_cur;
  logic [BIG_W-1:0] end_blk;
  logic [WORD_BITS-1:0] mark_mask;
  logic [BIT_W-1:0] mask_lo, mask_hi;

  logic [ADDR_W-1:0] rd_addr;
  logic wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  logic fc_we;
  logic [GRP_W-1:0] fc_wg;
  logic [CNT_W-1:0] fc_wd;

  scan_t sc;
  logic accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  gbba_bitmap_ram u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(rd_addr),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  gbba_run_scan u_scan (
    .word   (rd_data),
    .run_in (run_r),
    .want   (want_r),
    .is_last(w_r == WIG_W'(WORDS_PER_GROUP - 1)),
    .res    (sc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_r <= NGRP_W'(MAX_GROUPS);
      fdb_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GROUPS: groups_r <= cfg_data;
        CFG_FDB:    fdb_r    <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        free_cnt_r[g] <= CNT_W'(GROUP_BLOCKS);
      end
    end else if (fc_we) begin
      free_cnt_r[fc_wg] <= fc_wd;
    end
  end

  assign ngroups = (groups_r > NGRP_W'(MAX_GROUPS)) ? NGRP_W'(MAX_GROUPS) : groups_r;

  always_comb begin
    sum_free = '0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      if (NGRP_W'(g) < ngroups) begin
        sum_free = sum_free + BLK_W'(free_cnt_r[g]);
      end
    end
  end

  assign real_blk = blk_r - BLK_W'(fdb_r);
  assign free_g   = real_blk[BIG_W +: GRP_W];

  assign g_raw = {2'b00, start_r} + {1'b0, i_r};
  assign g_cur = (g_raw >= {1'b0, ngroups}) ? GRP_W'(g_raw - {1'b0, ngroups})
                                              : GRP_W'(g_raw);

  assign end_blk   = best_s_r + BIG_W'(best_len_r - CNT_W'(1));
  assign mask_lo   = (w_r == best_s_r[BIT_W +: WIG_W]) ? best_s_r[BIT_W-1:0] : '0;
  assign mask_hi   = (w_r == end_blk[BIT_W +: WIG_W]) ? end_blk[BIT_W-1:0] : '1;
  assign mark_mask = ({WORD_BITS{1'b1}} << mask_lo) &
                     ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mask_hi));

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    want_nxt      = want_r;
    status_nxt    = status_r;
    i_nxt         = i_r;
    g_nxt         = g_r;
    w_nxt         = w_r;
    run_nxt       = run_r;
    best_len_nxt  = best_len_r;
    best_g_nxt    = best_g_r;
    best_s_nxt    = best_s_r;
    first_nxt     = first_r;
    granted_nxt   = granted_r;
    out_valid_nxt = 1'b0;
    rd_addr       = {g_r, w_r};
    wr_en         = 1'b0;
    wr_addr       = {g_r, w_r};
    wr_data       = rd_data;
    fc_we         = 1'b0;
    fc_wg         = g_r;
    fc_wd         = free_cnt_r[g_r];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt   = ST_OK;
        first_nxt    = '0;
        granted_nxt  = '0;
        best_len_nxt = '0;
        best_g_nxt   = '0;
        best_s_nxt   = '0;
        i_nxt        = '0;
        if (req_r == REQ_FREE) begin
          g_nxt = free_g;
          w_nxt = real_blk[BIT_W +: WIG_W];
          if ((blk_r <= BLK_W'(fdb_r)) ||
              (real_blk[BLK_W-1:BIG_W] >= ngroups))
          begin
            status_nxt = ST_REFUSED;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_FRD;
          end
        end else if (want_r == '0) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_FIN;
        end else if (BLK_W'(want_r) > sum_free) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_FIN;
        end else begin
          if (want_r > CNT_W'(GROUP_BLOCKS)) begin
            want_nxt = CNT_W'(GROUP_BLOCKS);
          end
          if ({1'b0, start_r} >= ngroups) begin
            start_nxt = '0;
          end
          state_nxt = S_GSTART;
        end
      end
      S_GSTART: begin
        if (i_r == ngroups) begin
          if (best_len_r == '0) begin
            status_nxt = ST_NOSPACE;
            state_nxt  = S_FIN;
          end else begin
            g_nxt     = best_g_r;
            w_nxt     = best_s_r[BIT_W +: WIG_W];
            state_nxt = S_MRD;
          end
        end else if ((free_cnt_r[g_cur] == '0) || (free_cnt_r[g_cur] < best_len_r)) begin
          i_nxt = i_r + NGRP_W'(1);
        end else begin
          g_nxt     = g_cur;
          w_nxt     = '0;
          run_nxt   = '0;
          rd_addr   = {g_cur, WIG_W'(0)};
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = {g_r, w_r + WIG_W'(1)};
        if (sc.hit) begin
          best_len_nxt = want_r;
          best_g_nxt   = g_r;
          best_s_nxt   = BIG_W'(CNT_W'({w_r, sc.hit_pos}) - want_r + CNT_W'(1));
          i_nxt        = ngroups;
          state_nxt    = S_GSTART;
        end else begin
          if (sc.cand_len > best_len_r) begin
            best_len_nxt = sc.cand_len;
            best_g_nxt   = g_r;
            if (sc.cand_prev) begin
              best_s_nxt = BIG_W'(CNT_W'({w_r, BIT_W'(0)}) - sc.cand_len);
            end else begin
              best_s_nxt = BIG_W'(CNT_W'({w_r, sc.cand_pos}) - sc.cand_len + CNT_W'(1));
            end
          end
          if (w_r == WIG_W'(WORDS_PER_GROUP - 1)) begin
            i_nxt     = i_r + NGRP_W'(1);
            state_nxt = S_GSTART;
          end else begin
            w_nxt   = w_r + WIG_W'(1);
            run_nxt = sc.run_out;
          end
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data | mark_mask;
        if (w_r == end_blk[BIT_W +: WIG_W]) begin
          fc_we       = 1'b1;
          fc_wd       = (free_cnt_r[g_r] >= best_len_r) ? free_cnt_r[g_r] - best_len_r : '0;
          first_nxt   = BLK_W'({g_r, best_s_r}) + BLK_W'(fdb_r);
          granted_nxt = best_len_r;
          state_nxt   = S_FIN;
        end else begin
          w_nxt     = w_r + WIG_W'(1);
          state_nxt = S_MRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FWR;
      end
      S_FWR: begin
        if (!rd_data[real_blk[BIT_W-1:0]]) begin
          status_nxt = ST_DOUBLE;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~(WORD_BITS'(1) << real_blk[BIT_W-1:0]);
          fc_we   = 1'b1;
          fc_wd   = free_cnt_r[g_r] + CNT_W'(1);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the transaction fields and search state; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      start_r <= in_start_grp;
      want_r  <= in_requested_count;
      blk_r   <= in_block_number;
    end else begin
      start_r <= start_nxt;
      want_r  <= want_nxt;
    end
    status_r   <= status_nxt;
    i_r        <= i_nxt;
    g_r        <= g_nxt;
    w_r        <= w_nxt;
    run_r      <= run_nxt;
    best_len_r <= best_len_nxt;
    best_g_r   <= best_g_nxt;
    best_s_r   <= best_s_nxt;
    first_r    <= first_nxt;
    granted_r  <= granted_nxt;
    if (state_r == S_FIN) begin
      out_status_r <= status_r;
      out_first_r  <= first_r;
      out_count_r  <= granted_r;
      out_total_r  <= sum_free;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_block = out_first_r;
  assign out_grant_count = out_count_r;
  assign out_total_free  = out_total_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_grant_count == '0 && out_first_block == '0))
    else $error("failed transaction reports a grant");

  a_ok_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR && wr_en) |-> (best_len_r != '0))
    else $error("marking pass with an empty run");

endmodule
